>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> rtl/gjt_pkg.sv
// ----------------------------------------------------------------------------
// gjt_pkg
// shared widths, codes, command and status types for the text position block
// ----------------------------------------------------------------------------
package gjt_pkg;

  localparam int MAX_CHARS = 4096;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int POS_DEPTH = MAX_CHARS + 1;
  localparam int PARTS_W   = $clog2(MAX_CHARS + 3);

  localparam int X_W       = 40;
  localparam int CODE_W    = 16;
  localparam int ADV_W     = 17;
  localparam int POS_W     = 30;
  localparam int ERR_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;

  localparam int DIV_STEPS = X_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [ADV_W-1:0]  ADV_MAX   = 17'd65536;
  localparam logic [X_W-1:0]    POS_LIMIT = 40'h3fffffff;

  localparam logic [CODE_W-1:0] CODE_TAB   = 16'd9;
  localparam logic [CODE_W-1:0] CODE_SPACE = 16'd32;
  localparam logic [CODE_W-1:0] WIDE_MIN   = 16'd256;
  localparam logic [7:0]        WIDE_LO    = 8'h21;
  localparam logic [7:0]        WIDE_HI    = 8'h7e;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_WIDE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_POS_OVF  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUSTIFY_ON     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARAGRAPH_ENDS = 2'd2;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_RD_I      = 5'd2;
  localparam op_t OP_WIDE      = 5'd3;
  localparam op_t OP_TAB       = 5'd4;
  localparam op_t OP_TAB_DONE  = 5'd5;
  localparam op_t OP_SCAN_INIT = 5'd6;
  localparam op_t OP_RD_J      = 5'd7;
  localparam op_t OP_SCAN_ADD  = 5'd8;
  localparam op_t OP_EX_START  = 5'd9;
  localparam op_t OP_EX_DONE   = 5'd10;
  localparam op_t OP_PAD_DONE  = 5'd11;
  localparam op_t OP_RUN_EV    = 5'd12;
  localparam op_t OP_END       = 5'd13;
  localparam op_t OP_FETCH     = 5'd14;
  localparam op_t OP_FETCH_OUT = 5'd15;
  localparam op_t OP_ERR_OUT   = 5'd16;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic i_eq_n;
    logic j_eq_n;
    logic i_eq_j;
    logic is_wide;
    logic is_tab;
    logic is_space;
    logic div_busy;
    logic load_ok;
    logic err_set;
    logic fetch_last;
    logic out_free;
    logic out_valid;
  } status_t;

  function automatic logic wide_ok(input logic [CODE_W-1:0] c);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = c[15:8];
    lo = c[7:0];
    return (hi >= WIDE_LO) && (hi <= WIDE_HI) && (lo >= WIDE_LO) && (lo <= WIDE_HI);
  endfunction

endpackage

>>> rtl/gjt_channels.sv
// ----------------------------------------------------------------------------
// gjt channels
// valid/ready interfaces for the character input and the position output
// ----------------------------------------------------------------------------
interface gjt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] char_code;
  logic [16:0] advance;
  logic        final_char;

  modport source (output valid, kind, char_code, advance, final_char, input ready);
  modport sink   (input valid, kind, char_code, advance, final_char, output ready);
endinterface

interface gjt_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] position;
  logic [1:0]  error_code;
  logic        last_position;

  modport source (output valid, position, error_code, last_position, input ready);
  modport sink   (input valid, position, error_code, last_position, output ready);
endinterface

>>> rtl/grid_justified_text_positions_top.sv
// ----------------------------------------------------------------------------
// grid_justified_text_positions_top
// loads a line of characters, lays it out on a cell grid, returns positions
// ----------------------------------------------------------------------------
// load transaction: taken when valid while loading; fetch: passes a fetch-wait state,
//   then the output register takes the result; no new fetch is taken until then
// layout after the final load: wide chars, tabs and narrow runs, the runs scanned then padded
//   (shared 40-step divider: two divides per run, one per space or tab; it sets the pace)
// synchronous active-low reset: empty line, loading phase, cell width 1
// stores need no clearing pass, their contents are undefined until written
module grid_justified_text_positions_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gjt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gjt_pkg::CFG_W-1:0]     cfg_wdata,
  gjt_in_if.sink                        in_ch,
  gjt_out_if.source                     out_ch
);
  import gjt_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t sts;

  // sequencer: owns the input handshake and the layout walk
  gjt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_final (in_ch.final_char),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: stores, pen arithmetic, divider and the output register
  gjt_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .ld_code           (in_ch.char_code),
    .ld_adv            (in_ch.advance),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_position      (out_ch.position),
    .out_error_code    (out_ch.error_code),
    .out_last_position (out_ch.last_position)
  );

endmodule

>>> rtl/gjt_ram.sv
// ----------------------------------------------------------------------------
// gjt_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gjt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gjt_div.sv
// ----------------------------------------------------------------------------
// gjt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gjt_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [gjt_pkg::X_W-1:0]  dividend,
  input  logic [gjt_pkg::ADV_W-1:0] divisor,
  output logic                     busy,
  output logic [gjt_pkg::X_W-1:0]  quotient,
  output logic [gjt_pkg::ADV_W-1:0] remainder
);
  import gjt_pkg::*;

  logic [X_W-1:0]       quo_r;
  logic [ADV_W:0]       rem_r;
  logic [ADV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [ADV_W:0]       rem_sh;
  logic                 take;

  assign rem_sh = {rem_r[ADV_W-1:0], quo_r[X_W-1]};
  assign take   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[X_W-2:0], take};
      rem_r <= take ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[ADV_W-1:0];

endmodule

>>> rtl/gjt_datapath.sv
// ----------------------------------------------------------------------------
// gjt_datapath
// config registers, character and position stores, pen arithmetic, output reg
// ----------------------------------------------------------------------------
module gjt_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gjt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gjt_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [gjt_pkg::CODE_W-1:0]    ld_code,
  input  logic [gjt_pkg::ADV_W-1:0]     ld_adv,
  input  gjt_pkg::cmd_t                 cmd,
  output gjt_pkg::status_t              sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [gjt_pkg::POS_W-1:0]     out_position,
  output logic [gjt_pkg::ERR_W-1:0]     out_error_code,
  output logic                          out_last_position
);
  import gjt_pkg::*;

  logic [ADV_W-1:0]   cell_r;
  logic               just_r;
  logic               pend_r;
  logic [ADV_W-1:0]   cell_eff;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   rp_r;
  logic [ERR_W-1:0]   err_r;
  logic [X_W-1:0]     x_r;
  logic [CNT_W-1:0]   i_r;
  logic [CNT_W-1:0]   j_r;
  logic [X_W-1:0]     nat_r;
  logic [PARTS_W-1:0] parts_r;
  logic               at_end_r;
  logic               tab_next_r;
  logic [ADV_W-1:0]   extra_r;
  logic [X_W-1:0]     num_r;
  logic [X_W-1:0]     qprev_r;
  logic               fetch_last_r;
  logic               out_valid_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [ERR_W-1:0]   out_err_r;
  logic               out_last_r;

  logic               full;
  logic [ADV_W-1:0]   adv_clamp;
  logic               bad_wide;
  logic [ERR_W-1:0]   err_ld_nxt;
  logic [CNT_W-1:0]   rd_idx;
  logic [CODE_W-1:0]  code_rd;
  logic [ADV_W-1:0]   adv_rd;
  logic               pos_we;
  logic [CNT_W-1:0]   pos_waddr;
  logic [POS_W-1:0]   pos_rd;
  logic               is_space;
  logic               apply;
  logic [ADV_W-1:0]   extra_c;
  logic [PARTS_W-1:0] parts_adj;
  logic               div_start;
  logic [X_W-1:0]     div_dividend;
  logic [ADV_W-1:0]   div_divisor;
  logic               div_busy;
  logic [X_W-1:0]     div_quo;
  logic [ADV_W-1:0]   div_rem;
  logic               clear;

  // register write, cell width folded into 1..65536
  always_comb begin
    if (cfg_wdata == '0) begin
      cell_eff = ADV_W'(1);
    end else if (cfg_wdata > ADV_MAX) begin
      cell_eff = ADV_MAX;
    end else begin
      cell_eff = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= ADV_W'(1);
      just_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_WIDTH:     cell_r <= cell_eff;
        REG_JUSTIFY_ON:     just_r <= cfg_wdata[0];
        REG_PARAGRAPH_ENDS: pend_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // load checks
  assign full       = count_r >= CNT_W'(MAX_CHARS);
  assign adv_clamp  = (ld_adv > ADV_MAX) ? ADV_MAX : ld_adv;
  assign bad_wide   = (ld_code >= WIDE_MIN) && !wide_ok(ld_code);
  assign err_ld_nxt = full ? ERR_TOO_MANY :
                      (bad_wide && (err_r == ERR_OK)) ? ERR_BAD_WIDE : err_r;

  // stores
  assign rd_idx = (cmd.op == OP_RD_J) ? j_r : i_r;

  gjt_ram #(.WIDTH(CODE_W), .DEPTH(MAX_CHARS)) u_code_ram (
    .clk   (clk),
    .we    ((cmd.op == OP_LOAD) && !full),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (ld_code),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (code_rd)
  );

  gjt_ram #(.WIDTH(ADV_W), .DEPTH(MAX_CHARS)) u_adv_ram (
    .clk   (clk),
    .we    ((cmd.op == OP_LOAD) && !full),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (adv_clamp),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (adv_rd)
  );

  assign pos_we    = (cmd.op == OP_WIDE) || (cmd.op == OP_TAB) ||
                     (cmd.op == OP_RUN_EV) || (cmd.op == OP_END);
  assign pos_waddr = (cmd.op == OP_END) ? count_r : i_r;

  gjt_ram #(.WIDTH(POS_W), .DEPTH(POS_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (x_r[POS_W-1:0]),
    .raddr (rp_r),
    .rdata (pos_rd)
  );

  // run padding terms
  assign is_space  = code_rd == CODE_SPACE;
  assign apply     = just_r && (tab_next_r || (at_end_r && !pend_r));
  assign extra_c   = apply ? (cell_r - div_rem) : '0;
  assign parts_adj = (at_end_r && (parts_r != PARTS_W'(2))) ? (parts_r - 1'b1) : parts_r;

  // shared divider
  assign div_start = (cmd.op == OP_TAB) || (cmd.op == OP_EX_START) ||
                     (cmd.op == OP_EX_DONE) || ((cmd.op == OP_RUN_EV) && is_space);

  always_comb begin
    case (cmd.op)
      OP_TAB: begin
        div_dividend = x_r;
        div_divisor  = cell_r;
      end
      OP_EX_START: begin
        div_dividend = nat_r;
        div_divisor  = cell_r;
      end
      OP_EX_DONE: begin
        div_dividend = X_W'(extra_c);
        div_divisor  = ADV_W'(parts_adj);
      end
      default: begin
        div_dividend = num_r;
        div_divisor  = ADV_W'(parts_r);
      end
    endcase
  end

  gjt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign clear = (cmd.op == OP_ERR_OUT) || ((cmd.op == OP_FETCH_OUT) && fetch_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rp_r        <= '0;
      err_r       <= ERR_OK;
      x_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result takes the register, otherwise it empties on acceptance
      if ((cmd.op == OP_FETCH_OUT) || (cmd.op == OP_ERR_OUT)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (!full) begin
            count_r <= count_r + 1'b1;
          end
          err_r <= err_ld_nxt;
          i_r   <= '0;
          x_r   <= '0;
        end
        OP_WIDE: begin
          x_r <= x_r + X_W'(cell_r);
          i_r <= i_r + 1'b1;
        end
        OP_TAB_DONE: begin
          x_r <= x_r - X_W'(div_rem) + X_W'(cell_r);
          i_r <= i_r + 1'b1;
        end
        OP_SCAN_INIT: begin
          j_r     <= i_r;
          nat_r   <= x_r;
          parts_r <= PARTS_W'(2);
        end
        OP_SCAN_ADD: begin
          nat_r <= nat_r + X_W'(adv_rd);
          if (is_space) begin
            parts_r <= parts_r + 1'b1;
          end
          j_r <= j_r + 1'b1;
        end
        OP_EX_START: begin
          at_end_r   <= j_r == count_r;
          tab_next_r <= (j_r != count_r) && (code_rd == CODE_TAB);
        end
        OP_EX_DONE: begin
          extra_r <= extra_c;
          num_r   <= X_W'(extra_c);
          qprev_r <= '0;
          parts_r <= parts_adj;
        end
        OP_PAD_DONE: begin
          x_r     <= x_r + div_quo - qprev_r;
          qprev_r <= div_quo;
          num_r   <= num_r + X_W'(extra_r);
        end
        OP_RUN_EV: begin
          x_r <= x_r + X_W'(adv_rd);
          i_r <= i_r + 1'b1;
        end
        OP_END: begin
          if (x_r > POS_LIMIT) begin
            err_r <= ERR_POS_OVF;
          end
        end
        OP_FETCH: begin
          fetch_last_r <= rp_r == count_r;
        end
        OP_FETCH_OUT: begin
          out_pos_r   <= pos_rd;
          out_err_r   <= ERR_OK;
          out_last_r  <= fetch_last_r;
          if (!fetch_last_r) begin
            rp_r <= rp_r + 1'b1;
          end
        end
        OP_ERR_OUT: begin
          out_pos_r   <= '0;
          out_err_r   <= err_r;
          out_last_r  <= 1'b1;
        end
        default: ;
      endcase
      if (clear) begin
        count_r <= '0;
        rp_r    <= '0;
        err_r   <= ERR_OK;
        x_r     <= '0;
      end
    end
  end

  always_comb begin
    sts.i_eq_n     = i_r == count_r;
    sts.j_eq_n     = j_r == count_r;
    sts.i_eq_j     = i_r == j_r;
    sts.is_wide    = code_rd >= WIDE_MIN;
    sts.is_tab     = code_rd == CODE_TAB;
    sts.is_space   = is_space;
    sts.div_busy   = div_busy;
    sts.load_ok    = err_ld_nxt == ERR_OK;
    sts.err_set    = err_r != ERR_OK;
    sts.fetch_last = fetch_last_r;
    sts.out_free   = !out_valid_r || out_ready;
    sts.out_valid  = out_valid_r;
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_error_code    = out_err_r;
  assign out_last_position = out_last_r;

endmodule

>>> rtl/gjt_ctrl.sv
// ----------------------------------------------------------------------------
// gjt_ctrl
// sequencer for loading, line layout and position fetch
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gjt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_kind,
  input  logic             in_final,
  output logic             in_ready,
  output gjt_pkg::cmd_t    cmd,
  input  gjt_pkg::status_t sts
);
  import gjt_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_LF   = 4'd1;
  localparam logic [3:0] S_LC   = 4'd2;
  localparam logic [3:0] S_TABW = 4'd3;
  localparam logic [3:0] S_SR   = 4'd4;
  localparam logic [3:0] S_SE   = 4'd5;
  localparam logic [3:0] S_EXW  = 4'd6;
  localparam logic [3:0] S_PADW = 4'd7;
  localparam logic [3:0] S_RR   = 4'd8;
  localparam logic [3:0] S_RE   = 4'd9;
  localparam logic [3:0] S_END  = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;
  localparam logic [3:0] S_FW   = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       in_accept;

  assign in_ready  = (state_r == S_LOAD) || ((state_r == S_EMIT) && sts.out_free);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_LOAD: begin
        if (in_accept && (in_kind == KIND_LOAD)) begin
          cmd.op = OP_LOAD;
          if (in_final) begin
            state_nxt = sts.load_ok ? S_LF : S_EMIT;
          end
        end
      end
      S_LF: begin
        if (sts.i_eq_n) begin
          state_nxt = S_END;
        end else begin
          cmd.op    = OP_RD_I;
          state_nxt = S_LC;
        end
      end
      S_LC: begin
        if (sts.is_wide) begin
          cmd.op    = OP_WIDE;
          state_nxt = S_LF;
        end else if (sts.is_tab) begin
          cmd.op    = OP_TAB;
          state_nxt = S_TABW;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = S_SR;
        end
      end
      S_TABW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_TAB_DONE;
          state_nxt = S_LF;
        end
      end
      S_SR: begin
        if (sts.j_eq_n) begin
          cmd.op    = OP_EX_START;
          state_nxt = S_EXW;
        end else begin
          cmd.op    = OP_RD_J;
          state_nxt = S_SE;
        end
      end
      S_SE: begin
        if (!sts.is_wide && !sts.is_tab) begin
          cmd.op    = OP_SCAN_ADD;
          state_nxt = S_SR;
        end else begin
          cmd.op    = OP_EX_START;
          state_nxt = S_EXW;
        end
      end
      S_EXW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_EX_DONE;
          state_nxt = S_PADW;
        end
      end
      S_PADW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_PAD_DONE;
          state_nxt = S_RR;
        end
      end
      S_RR: begin
        if (sts.i_eq_j) begin
          state_nxt = S_LF;
        end else begin
          cmd.op    = OP_RD_I;
          state_nxt = S_RE;
        end
      end
      S_RE: begin
        cmd.op    = OP_RUN_EV;
        state_nxt = sts.is_space ? S_PADW : S_RR;
      end
      S_END: begin
        cmd.op    = OP_END;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (in_accept && (in_kind == KIND_FETCH)) begin
          if (sts.err_set) begin
            cmd.op    = OP_ERR_OUT;
            state_nxt = S_LOAD;
          end else begin
            cmd.op    = OP_FETCH;
            state_nxt = S_FW;
          end
        end
      end
      S_FW: begin
        cmd.op    = OP_FETCH_OUT;
        state_nxt = sts.fetch_last ? S_LOAD : S_EMIT;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_fetch_fills_out, state_r == S_FW, sts.out_valid)
  `ASSERT_IMPLY(a_div_free_on_start, (cmd.op == OP_TAB) || (cmd.op == OP_EX_START), !sts.div_busy)
  `ASSERT_NEXT(a_bad_line_skips_layout, (state_r == S_LOAD) && in_accept && !in_kind && in_final && !sts.load_ok, state_r == S_EMIT)

endmodule

>>> test/gjt_position_checker.sv
// ----------------------------------------------------------------------------
// gjt position checker
// watches both channels, lays out each loaded line and compares the positions
// ----------------------------------------------------------------------------
module gjt_position_checker
  import gjt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  gjt_in_if.sink             in_mon,
  gjt_out_if.sink            out_mon,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [ERR_W-1:0] error_code;
    logic             last_position;
  } pos_result_t;

  logic [CFG_W-1:0]  cell_width_q;
  logic              justify_q;
  logic              para_ends_q;
  logic [CODE_W-1:0] codes [MAX_CHARS];
  logic [ADV_W-1:0]  advs [MAX_CHARS];
  logic [POS_W-1:0]  positions [MAX_CHARS+1];
  int                n_chars;
  int                rd_ptr;
  logic [ERR_W-1:0]  line_err;
  bit                emitting;
  pos_result_t       expected_positions [$];

  function automatic longint unsigned pad_part(longint unsigned gap, longint unsigned k,
                                               longint unsigned parts);
    return gap * (k + 1) / parts - gap * k / parts;
  endfunction

  // queues one predicted result at the tail
  function automatic void add_expected(input logic [POS_W-1:0] p, input logic [ERR_W-1:0] e,
                                       input logic l);
    pos_result_t r;
    r.position      = p;
    r.error_code    = e;
    r.last_position = l;
    expected_positions.insert(expected_positions.size(), r);
  endfunction

  // lays out the stored line, sets the overflow error when the end runs past the limit
  task automatic lay_out_line();
    longint unsigned cell_sz, x, natural, gap, parts, k;
    int i, stop;
    bit at_end, tab_next;
    cell_sz = (cell_width_q == '0) ? 64'd1 :
              (cell_width_q > 17'd65536 ? 64'd65536 : 64'(cell_width_q));
    x = 0;
    i = 0;
    while (i < n_chars) begin
      if (codes[i] >= WIDE_MIN) begin
        positions[i] = x[POS_W-1:0];
        x += cell_sz;
        i++;
      end else if (codes[i] == CODE_TAB) begin
        positions[i] = x[POS_W-1:0];
        x = (x / cell_sz + 1) * cell_sz;
        i++;
      end else begin
        stop = i;
        natural = x;
        parts = 2;
        k = 1;
        while (stop < n_chars && codes[stop] < WIDE_MIN && codes[stop] != CODE_TAB) begin
          natural += advs[stop];
          if (codes[stop] == CODE_SPACE) parts++;
          stop++;
        end
        gap = (natural / cell_sz + 1) * cell_sz - natural;
        at_end = (stop == n_chars);
        tab_next = !at_end && codes[stop] == CODE_TAB;
        if (!(justify_q && (tab_next || (at_end && !para_ends_q)))) gap = 0;
        if (at_end && parts != 2) parts--;
        x += pad_part(gap, 0, parts);
        while (i < stop) begin
          positions[i] = x[POS_W-1:0];
          x += advs[i];
          if (codes[i] == CODE_SPACE) begin
            x += pad_part(gap, k, parts);
            k++;
          end
          i++;
        end
      end
    end
    positions[n_chars] = x[POS_W-1:0];
    if (x > POS_LIMIT) line_err = ERR_POS_OVF;
  endtask

  task automatic clear_line();
    n_chars = 0;
    rd_ptr = 0;
    line_err = ERR_OK;
    emitting = 0;
  endtask

  always @(posedge clk) begin
    pos_result_t got, exp;
    logic [ADV_W-1:0] adv;
    if (!rst_n) begin
      cell_width_q <= CFG_W'(1);
      justify_q <= 1'b0;
      para_ends_q <= 1'b0;
      clear_line();
      expected_positions.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_WIDTH:     cell_width_q <= cfg_wdata;
          REG_JUSTIFY_ON:     justify_q <= cfg_wdata[0];
          REG_PARAGRAPH_ENDS: para_ends_q <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_LOAD && !emitting) begin
          adv = in_mon.advance > ADV_MAX ? ADV_MAX : in_mon.advance;
          if (n_chars >= MAX_CHARS) line_err = ERR_TOO_MANY;
          else begin
            codes[n_chars] = in_mon.char_code;
            advs[n_chars] = adv;
            n_chars++;
            if (in_mon.char_code >= WIDE_MIN && !wide_ok(in_mon.char_code)
                && line_err == ERR_OK) line_err = ERR_BAD_WIDE;
          end
          if (in_mon.final_char) begin
            if (line_err == ERR_OK) lay_out_line();
            rd_ptr = 0;
            emitting = 1;
          end
        end else if (in_mon.kind == KIND_FETCH && emitting) begin
          if (line_err != ERR_OK) begin
            add_expected('0, line_err, 1'b1);
            clear_line();
          end else if (rd_ptr >= n_chars) begin
            add_expected(positions[n_chars], ERR_OK, 1'b1);
            clear_line();
          end else begin
            add_expected(positions[rd_ptr], ERR_OK, 1'b0);
            rd_ptr++;
          end
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.position, out_mon.error_code, out_mon.last_position};
        if (expected_positions.size() == 0) begin
          $error("unexpected result transaction position=%0d", got.position);
          fail_count <= fail_count + 1;
        end else begin
          exp = expected_positions.pop_front();
          if (got.position !== exp.position)
            $error("position: expected %0d, got %0d", exp.position, got.position);
          if (got.error_code !== exp.error_code)
            $error("error_code: expected %0d, got %0d", exp.error_code, got.error_code);
          if (got.last_position !== exp.last_position)
            $error("last_position: expected %0d, got %0d",
                   exp.last_position, got.last_position);
          if (got !== exp) fail_count <= fail_count + 1;
        end
      end
    end
    pending_count = expected_positions.size();
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives lines of narrow, wide, tab and space characters through the block,
// with random bursts and stalls, under several grid and justification settings
// ----------------------------------------------------------------------------
module testbench;
  import gjt_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending_count;
  int                   cycle_count;
  int                   load_count;
  bit                   long_hold;

  gjt_in_if  in_ch ();
  gjt_out_if out_ch ();

  grid_justified_text_positions_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  gjt_position_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit: layout is slow on long lines of spaces, so this is generous
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall pattern, runs of full speed, and one long hold-off
  initial begin
    int mode;
    int stretch;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(1, 30);
      repeat (stretch) begin
        out_ch.ready <= (mode == 0) ? 1'b1 : (mode == 1 ? ($urandom_range(0, 7) != 0)
                                                        : ($urandom_range(0, 2) == 0));
        @(posedge clk);
      end
    end
  end

  // sender gap state: bursts of random length separated by random gaps
  int burst_left;

  // offers one transaction and waits for its acceptance
  task automatic send(input logic kind, input logic [15:0] code,
                      input logic [16:0] adv, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.char_code  <= code;
    in_ch.advance    <= adv;
    in_ch.final_char <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kind == KIND_LOAD) load_count++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // a final load may still be laying out, give it time before a config write
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // sends n fetches; a line of len characters needs len + 1 to reach the end-of-line result
  task automatic fetch_line(input int n);
    repeat (n) send(KIND_FETCH, 16'($urandom), 17'($urandom), 1'($urandom));
  endtask

  function automatic logic [15:0] rand_code();
    int pick;
    logic [15:0] c;
    pick = $urandom_range(0, 19);
    if (pick < 5) return CODE_SPACE;
    if (pick < 7) return CODE_TAB;
    if (pick < 9) begin
      c[15:8] = 8'($urandom_range(8'h21, 8'h7e));
      c[7:0]  = 8'($urandom_range(8'h21, 8'h7e));
      return c;
    end
    if (pick == 9) return 16'($urandom);  // any code, mostly a bad wide one
    return 16'($urandom_range(0, 255));
  endfunction

  function automatic logic [16:0] rand_adv();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 17'($urandom);  // every bit, saturates above 65536
    if (pick == 1) return 17'd65536;
    if (pick == 2) return 17'd0;
    return 17'($urandom_range(0, 300));
  endfunction

  // one random line, then its fetches; sometimes noise around it
  task automatic random_line();
    int len;
    len = $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) send(KIND_FETCH, 16'($urandom), 17'($urandom), 1'($urandom));
    for (int i = 0; i < len; i++)
      send(KIND_LOAD, rand_code(), rand_adv(), i == len - 1);
    if ($urandom_range(0, 9) == 0) send(KIND_LOAD, 16'($urandom), 17'($urandom), 1'($urandom));
    fetch_line(len + 1);
  endtask

  task automatic directed_line();
    // narrow, spaces, tab, wide, bad wide, extremes of code and advance
    send(KIND_FETCH, 16'hffff, 17'h1ffff, 1);  // fetch on empty text, ignored
    send(KIND_LOAD, 16'd65, 17'd0, 0);
    send(KIND_LOAD, CODE_SPACE, 17'h1ffff, 0);
    send(KIND_LOAD, 16'd66, 17'd7, 0);
    send(KIND_LOAD, CODE_TAB, 17'd3, 0);
    send(KIND_LOAD, 16'h2121, 17'd0, 0);
    send(KIND_LOAD, 16'h7e7e, 17'd0, 0);
    send(KIND_LOAD, CODE_SPACE, 17'd5, 0);
    send(KIND_LOAD, 16'd255, 17'd65536, 1);
    send(KIND_LOAD, 16'd1, 17'd1, 0);        // load while emitting, ignored
    fetch_line(9);
    send(KIND_LOAD, 16'h2020, 17'd0, 0);     // bad wide code
    send(KIND_LOAD, 16'hffff, 17'd0, 1);
    fetch_line(1);
    send(KIND_LOAD, CODE_TAB, 17'd0, 1);     // a lone tab
    fetch_line(2);
  endtask

  initial begin
    int lines;
    cycle_count = 0;
    load_count = 0;
    burst_left = 0;
    long_hold = 0;
    rst_n = 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_CELL_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_LOAD;
    in_ch.char_code <= '0;
    in_ch.advance <= '0;
    in_ch.final_char <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_line();
    wait_drained();

    // settings sweep: cell width extremes (0 and above 65536 clamp), justify, paragraph
    for (int phase_i = 0; phase_i < 8; phase_i++) begin
      case (phase_i)
        0: write_reg(REG_CELL_WIDTH, 17'd16);
        1: write_reg(REG_CELL_WIDTH, 17'd0);
        2: write_reg(REG_CELL_WIDTH, 17'h1ffff);
        3: write_reg(REG_CELL_WIDTH, 17'd65536);
        default: write_reg(REG_CELL_WIDTH, 17'($urandom_range(1, 1000)));
      endcase
      write_reg(REG_JUSTIFY_ON, phase_i == 0 ? 17'd0 : {16'd0, 1'(phase_i != 5)});
      write_reg(REG_PARAGRAPH_ENDS, {16'd0, 1'(phase_i[0])});
      if (phase_i == 2) begin
        // hold the result side off while lines keep coming so the block stalls
        long_hold = 1;
      end
      lines = (phase_i == 7) ? 9 : 7;
      repeat (lines) random_line();
      // pause until every expected result has come
      wait_drained();
    end

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
